### hw/rtl/tmk_pkg.sv
// shared constants, types and helper functions of the thin multipole kick block
// no dependencies, compile first
`timescale 1ns / 1ps

package tmk_pkg;

  localparam int ORDER_MAX = 4;
  localparam int FRAC_BITS = 24;

  localparam int CoefW   = 48;
  localparam int CoordW  = 32;
  localparam int OpW     = CoordW + 1;
  localparam int AccW    = CoefW + 2;
  localparam int OrderW  = 3;
  localparam int DataW   = 32;
  localparam int PaddrW  = 4;

  localparam int TableDepth = 2 * ORDER_MAX;
  localparam int AddrW      = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int IdxW       = (ORDER_MAX > 1) ? $clog2(ORDER_MAX) : 1;
  localparam int NumW       = $clog2(ORDER_MAX + 1);

  localparam logic REQ_TRACK = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  typedef enum logic [1:0] {
    REG_KICK_LENGTH = 2'd0,
    REG_INV_RADIUS  = 2'd1,
    REG_FIELD_ORDER = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [DataW-1:0]  kick_length;
    logic [DataW-1:0]  inv_radius;
    logic [OrderW-1:0] field_order;
  } cfg_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic             sat;
    logic [CoefW-1:0] res;
  } mul_rsp_t;

  // entry k holds b[k], entry ORDER_MAX+k holds a[k]
  function automatic logic [AddrW-1:0] coef_addr(input logic skew, input logic [IdxW-1:0] idx);
    return AddrW'(int'(skew) * ORDER_MAX + int'(idx));
  endfunction

  function automatic logic ovf_coef(input logic signed [AccW-1:0] v);
    return v[AccW-1:CoefW-1] != {(AccW-CoefW+1){v[AccW-1]}};
  endfunction

  function automatic logic signed [CoefW-1:0] clip_coef(input logic signed [AccW-1:0] v);
    if (ovf_coef(v)) begin
      return {v[AccW-1], {(CoefW-1){~v[AccW-1]}}};
    end
    return v[CoefW-1:0];
  endfunction

  function automatic logic ovf_coord(input logic signed [AccW-1:0] v);
    return v[AccW-1:CoordW-1] != {(AccW-CoordW+1){v[AccW-1]}};
  endfunction

  function automatic logic signed [CoordW-1:0] clip_coord(input logic signed [AccW-1:0] v);
    if (ovf_coord(v)) begin
      return {v[AccW-1], {(CoordW-1){~v[AccW-1]}}};
    end
    return v[CoordW-1:0];
  endfunction

endpackage

### hw/rtl/tmk_channels.sv
// valid/ready channel interfaces for request and result transactions
// no dependencies on other files
`timescale 1ns / 1ps

interface tmk_req_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [1:0]         coef_index;
  logic               coef_skew;
  logic signed [47:0] coef_value;
  logic signed [31:0] pos_x;
  logic signed [31:0] mom_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] mom_y;
  logic signed [31:0] energy_dev;
  logic signed [31:0] path_len;

  modport source (
    output valid, req_type, coef_index, coef_skew, coef_value,
           pos_x, mom_x, pos_y, mom_y, energy_dev, path_len,
    input  ready
  );
  modport sink (
    input  valid, req_type, coef_index, coef_skew, coef_value,
           pos_x, mom_x, pos_y, mom_y, energy_dev, path_len,
    output ready
  );
endinterface

interface tmk_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_pos_x;
  logic signed [31:0] new_mom_x;
  logic signed [31:0] new_pos_y;
  logic signed [31:0] new_mom_y;
  logic signed [31:0] new_energy_dev;
  logic signed [31:0] new_path_len;
  logic               sat_flag;

  modport source (
    output valid, new_pos_x, new_mom_x, new_pos_y, new_mom_y,
           new_energy_dev, new_path_len, sat_flag,
    input  ready
  );
  modport sink (
    input  valid, new_pos_x, new_mom_x, new_pos_y, new_mom_y,
           new_energy_dev, new_path_len, sat_flag,
    output ready
  );
endinterface

### hw/rtl/tmk_ram.sv
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module tmk_ram #(
  parameter int Width = 48,
  parameter int Depth = 8,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/tmk_fxmul.sv
// shared fixed point multiplier: floor(c*v / 2^FRAC_BITS) saturated to 48 bits
// two 48x17 partial products, low digit first, then combine; depends on tmk_pkg
`timescale 1ns / 1ps

module tmk_fxmul (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic signed [tmk_pkg::CoefW-1:0] c_i,
  input  logic signed [tmk_pkg::OpW-1:0]   v_i,
  output tmk_pkg::mul_rsp_t               rsp_o
);
  import tmk_pkg::*;

  localparam int SplitW = 16;
  localparam int HiW    = OpW - SplitW;
  localparam int ProdW  = CoefW + HiW;
  localparam int FullW  = CoefW + OpW;
  localparam int QuotW  = FullW - FRAC_BITS;

  logic                    s1_q, s2_q, done_q;
  logic signed [CoefW-1:0] c_q;
  logic signed [HiW-1:0]   vh_q;
  logic signed [ProdW-1:0] lo_q, hi_q;
  logic signed [CoefW-1:0] res_q;
  logic                    sat_q;

  logic signed [FullW-1:0] full;
  logic signed [QuotW-1:0] quot;
  logic                    ovf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= 1'b0;
      s2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      s1_q   <= start_i;
      s2_q   <= s1_q;
      done_q <= s2_q;
    end
  end

  // low digit is unsigned, high digit carries the sign
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      c_q  <= c_i;
      vh_q <= v_i[OpW-1:SplitW];
      lo_q <= c_i * $signed({1'b0, v_i[SplitW-1:0]});
    end
    if (s1_q) begin
      hi_q <= c_q * vh_q;
    end
    if (s2_q) begin
      res_q <= ovf ? {quot[QuotW-1], {(CoefW-1){~quot[QuotW-1]}}} : quot[CoefW-1:0];
      sat_q <= ovf;
    end
  end

  assign full = $signed({hi_q, {SplitW{1'b0}}}) + FullW'(lo_q);
  assign quot = full[FullW-1:FRAC_BITS];
  assign ovf  = quot[QuotW-1:CoefW-1] != {(QuotW-CoefW+1){quot[QuotW-1]}};

  assign rsp_o.busy = s1_q | s2_q;
  assign rsp_o.done = done_q;
  assign rsp_o.sat  = sat_q;
  assign rsp_o.res  = res_q;

endmodule

### hw/rtl/tmk_cfg.sv
// apb register file: kick length, inverse radius, field order
// depends on tmk_pkg
`timescale 1ns / 1ps

module tmk_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tmk_pkg::PaddrW-1:0]  paddr,
  input  logic [tmk_pkg::DataW-1:0]   pwdata,
  output logic [tmk_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output tmk_pkg::cfg_t               cfg_o
);
  import tmk_pkg::*;

  cfg_t cfg_q;
  logic wr_en;

  assign wr_en = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kick_length <= '0;
      cfg_q.inv_radius  <= '0;
      cfg_q.field_order <= OrderW'(1);
    end else if (wr_en) begin
      unique case (paddr[PaddrW-1:2])
        REG_KICK_LENGTH: cfg_q.kick_length <= pwdata;
        REG_INV_RADIUS:  cfg_q.inv_radius  <= pwdata;
        REG_FIELD_ORDER: cfg_q.field_order <= pwdata[OrderW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[PaddrW-1:2])
      REG_KICK_LENGTH: prdata = cfg_q.kick_length;
      REG_INV_RADIUS:  prdata = cfg_q.inv_radius;
      REG_FIELD_ORDER: prdata = DataW'(cfg_q.field_order);
      default:         prdata = '0;
    endcase
  end

  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

endmodule

### hw/rtl/thin_multipole_kick.sv
// thin multipole kick: sequencer and datapath around one shared multiplier
// depends on tmk_pkg, tmk_channels, tmk_ram, tmk_fxmul, tmk_cfg
//
// usage: requests arrive on the req channel (valid/ready). a write request
// stores one normal or skew coefficient and produces no result; a track
// request kicks one particle and produces one transaction on the rsp channel.
// registers (kick length, inverse radius, field order) sit on the apb port and
// are to be written only while the block is idle; the block itself does not
// enforce this. a track request runs n-1 horner orders, n the effective field
// order; each horner order costs four passes through the shared multiplier
// plus two load steps, and the tail costs five more passes. the block goes
// back to idle as the result is registered and can then take the next request.
// one track request is in flight at a time; write requests leave the block idle.
// the result sits in an output register, so a new request is taken while the
// previous result still waits; when the receiver stalls, the next result
// holds in the final step until the output register frees up.
// reset clears the coefficient table to zero (valid bits), the field order
// to one, and the other registers to zero.
`timescale 1ns / 1ps

module thin_multipole_kick (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  tmk_req_if.sink                    req,
  tmk_rsp_if.source                  rsp,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tmk_pkg::PaddrW-1:0] paddr,
  input  logic [tmk_pkg::DataW-1:0]  pwdata,
  output logic [tmk_pkg::DataW-1:0]  prdata,
  output logic                       pready
);
  import tmk_pkg::*;

  typedef enum logic [17:0] {
    ST_IDLE    = 18'h00001,
    ST_LDRE    = 18'h00002,
    ST_LDIM    = 18'h00004,
    ST_RE_INIT = 18'h00008,
    ST_RE_T0   = 18'h00010,
    ST_RE_T1   = 18'h00020,
    ST_IM_INIT = 18'h00040,
    ST_IM_T0   = 18'h00080,
    ST_IM_T1   = 18'h00100,
    ST_HXS     = 18'h00200,
    ST_HX      = 18'h00400,
    ST_TS      = 18'h00800,
    ST_G       = 18'h01000,
    ST_GL      = 18'h02000,
    ST_PX      = 18'h04000,
    ST_PY      = 18'h08000,
    ST_CT      = 18'h10000,
    ST_FIN     = 18'h20000
  } st_e;

  st_e st_q, st_d;

  cfg_t     cfg;
  mul_rsp_t mul_rsp;

  logic                    mul_start;
  logic signed [CoefW-1:0] mul_c;
  logic signed [OpW-1:0]   mul_v;

  logic                    ram_we;
  logic [AddrW-1:0]        ram_waddr, ram_raddr;
  logic [CoefW-1:0]        ram_rdata;
  logic [TableDepth-1:0]   valid_q;
  logic                    rdval_q;

  logic signed [CoordW-1:0] x_q, px_q, y_q, py_q, dl_q, ct_q;
  logic signed [CoefW-1:0]  re_q, im_q, tmp_q, hx_q;
  logic signed [AccW-1:0]   acc_q;
  logic [IdxW-1:0]          i_q;
  logic                     sat_q;

  logic                     out_valid_q;
  logic signed [CoordW-1:0] out_px_q, out_mpx_q, out_py_q, out_mpy_q, out_dl_q, out_ct_q;
  logic                     out_sat_q;

  logic                     req_fire, trk_fire, wr_fire, done, can_out;
  logic [NumW-1:0]          n_eff;
  logic [IdxW-1:0]          idx_top, idx_nm2;
  logic signed [CoefW-1:0]  coef;
  logic signed [AccW-1:0]   res_ext, sum_a, sum_d;
  logic                     sum_neg, wb_coef, wb_coord;
  logic signed [OpW-1:0]    x_op, y_op, h_op, l_op;

  tmk_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tmk_ram #(
    .Width (CoefW),
    .Depth (TableDepth)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (req.coef_value),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tmk_fxmul u_fxmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .c_i     (mul_c),
    .v_i     (mul_v),
    .rsp_o   (mul_rsp)
  );

  assign req.ready = (st_q == ST_IDLE);
  assign req_fire  = req.valid & req.ready;
  assign trk_fire  = req_fire & (req.req_type == REQ_TRACK);
  assign wr_fire   = req_fire & (req.req_type == REQ_WRITE);
  assign done      = mul_rsp.done;
  assign can_out   = ~out_valid_q | rsp.ready;

  // indexes past the table are dropped
  assign ram_we    = wr_fire & (int'(req.coef_index) < ORDER_MAX);
  assign ram_waddr = coef_addr(req.coef_skew, IdxW'(req.coef_index));

  always_comb begin
    if (cfg.field_order == '0) begin
      n_eff = NumW'(1);
    end else if (int'(cfg.field_order) > ORDER_MAX) begin
      n_eff = NumW'(ORDER_MAX);
    end else begin
      n_eff = NumW'(cfg.field_order);
    end
  end

  assign idx_top = IdxW'(n_eff - NumW'(1));
  assign idx_nm2 = (n_eff >= NumW'(2)) ? IdxW'(n_eff - NumW'(2)) : '0;

  // entries never written read as zero
  assign coef    = rdval_q ? $signed(ram_rdata) : '0;
  assign res_ext = AccW'($signed(mul_rsp.res));

  assign x_op = OpW'(x_q);
  assign y_op = OpW'(y_q);
  assign h_op = OpW'($signed(cfg.inv_radius));
  assign l_op = $signed({1'b0, cfg.kick_length});

  always_comb begin
    unique case (st_q)
      ST_IDLE:  ram_raddr = coef_addr(1'b0, idx_top);
      ST_LDRE:  ram_raddr = coef_addr(1'b1, idx_top);
      ST_LDIM:  ram_raddr = coef_addr(1'b0, idx_nm2);
      ST_RE_T1: ram_raddr = coef_addr(1'b1, i_q);
      ST_IM_T1: ram_raddr = coef_addr(1'b0, i_q - IdxW'(1));
      default:  ram_raddr = coef_addr(1'b0, i_q);
    endcase
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_start = 1'b0;
    mul_c     = re_q;
    mul_v     = x_op;
    unique case (st_q)
      ST_RE_INIT: begin
        mul_start = 1'b1;
      end
      ST_RE_T0: begin
        mul_start = done;
        mul_c     = im_q;
        mul_v     = y_op;
      end
      ST_IM_INIT: begin
        mul_start = 1'b1;
        mul_c     = im_q;
      end
      ST_IM_T0: begin
        mul_start = done;
        mul_v     = y_op;
      end
      ST_HXS: begin
        mul_start = 1'b1;
        mul_c     = CoefW'(x_q);
        mul_v     = h_op;
      end
      ST_TS: begin
        mul_start = 1'b1;
        mul_c     = tmp_q;
        mul_v     = h_op;
      end
      ST_GL: begin
        mul_start = 1'b1;
        mul_c     = tmp_q;
        mul_v     = l_op;
      end
      ST_PX: begin
        mul_start = done;
        mul_c     = im_q;
        mul_v     = l_op;
      end
      ST_PY: begin
        mul_start = done;
        mul_c     = hx_q;
        mul_v     = l_op;
      end
      default: ;
    endcase
  end

  // one shared adder takes the product into whatever the step needs
  always_comb begin
    sum_neg = 1'b0;
    unique case (st_q)
      ST_RE_T1: begin
        sum_a   = acc_q;
        sum_neg = 1'b1;
      end
      ST_HX: begin
        sum_a   = AccW'(dl_q);
        sum_neg = 1'b1;
      end
      ST_G: begin
        sum_a   = AccW'(re_q);
        sum_neg = 1'b1;
      end
      ST_PX: begin
        sum_a   = AccW'(px_q);
        sum_neg = 1'b1;
      end
      ST_PY:   sum_a = AccW'(py_q);
      ST_FIN:  sum_a = AccW'(ct_q);
      default: sum_a = acc_q;
    endcase
    sum_d = sum_neg ? (sum_a - res_ext) : (sum_a + res_ext);
  end

  assign wb_coef  = done & ((st_q == ST_RE_T1) | (st_q == ST_IM_T1) |
                            (st_q == ST_HX) | (st_q == ST_G));
  assign wb_coord = done & ((st_q == ST_PX) | (st_q == ST_PY));

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE:    if (trk_fire) st_d = ST_LDRE;
      ST_LDRE:    st_d = ST_LDIM;
      ST_LDIM:    st_d = (n_eff == NumW'(1)) ? ST_HXS : ST_RE_INIT;
      ST_RE_INIT: st_d = ST_RE_T0;
      ST_RE_T0:   if (done) st_d = ST_RE_T1;
      ST_RE_T1:   if (done) st_d = ST_IM_INIT;
      ST_IM_INIT: st_d = ST_IM_T0;
      ST_IM_T0:   if (done) st_d = ST_IM_T1;
      ST_IM_T1:   if (done) st_d = (i_q == '0) ? ST_HXS : ST_RE_INIT;
      ST_HXS:     st_d = ST_HX;
      ST_HX:      if (done) st_d = ST_TS;
      ST_TS:      st_d = ST_G;
      ST_G:       if (done) st_d = ST_GL;
      ST_GL:      st_d = ST_PX;
      ST_PX:      if (done) st_d = ST_PY;
      ST_PY:      if (done) st_d = ST_CT;
      ST_CT:      if (done) st_d = ST_FIN;
      ST_FIN:     if (can_out) st_d = ST_IDLE;
      default:    st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (ram_we) begin
        valid_q[ram_waddr] <= 1'b1;
      end
      if ((st_q == ST_FIN) && can_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rdval_q <= valid_q[ram_raddr];

    if (trk_fire) begin
      x_q   <= req.pos_x;
      px_q  <= req.mom_x;
      y_q   <= req.pos_y;
      py_q  <= req.mom_y;
      dl_q  <= req.energy_dev;
      ct_q  <= req.path_len;
      sat_q <= 1'b0;
    end else begin
      sat_q <= sat_q | (done & mul_rsp.sat) | (wb_coef & ovf_coef(sum_d)) |
               (wb_coord & ovf_coord(sum_d));
    end

    unique case (st_q)
      ST_LDRE: re_q <= coef;
      ST_LDIM: begin
        im_q <= coef;
        i_q  <= idx_nm2;
      end
      ST_RE_INIT, ST_IM_INIT: acc_q <= AccW'(coef);
      ST_RE_T0, ST_IM_T0: if (done) acc_q <= sum_d;
      ST_RE_T1: if (done) tmp_q <= clip_coef(sum_d);
      ST_IM_T1: begin
        if (done) begin
          im_q <= clip_coef(sum_d);
          re_q <= tmp_q;
          if (i_q != '0) begin
            i_q <= i_q - IdxW'(1);
          end
        end
      end
      ST_HX: begin
        if (done) begin
          hx_q  <= $signed(mul_rsp.res);
          tmp_q <= clip_coef(sum_d);
        end
      end
      ST_G:  if (done) tmp_q <= clip_coef(sum_d);
      ST_PX: if (done) px_q <= clip_coord(sum_d);
      ST_PY: if (done) py_q <= clip_coord(sum_d);
      ST_FIN: begin
        if (can_out) begin
          out_px_q  <= x_q;
          out_mpx_q <= px_q;
          out_py_q  <= y_q;
          out_mpy_q <= py_q;
          out_dl_q  <= dl_q;
          out_ct_q  <= clip_coord(sum_d);
          out_sat_q <= sat_q | ovf_coord(sum_d);
        end
      end
      default: ;
    endcase
  end

  assign rsp.valid          = out_valid_q;
  assign rsp.new_pos_x      = out_px_q;
  assign rsp.new_mom_x      = out_mpx_q;
  assign rsp.new_pos_y      = out_py_q;
  assign rsp.new_mom_y      = out_mpy_q;
  assign rsp.new_energy_dev = out_dl_q;
  assign rsp.new_path_len   = out_ct_q;
  assign rsp.sat_flag       = out_sat_q;

`ifndef SYNTHESIS
  a_mul_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |-> !mul_rsp.busy)
    else $error("multiplier started while busy");

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(st_q == ST_FIN))
    else $error("result raised outside the final step");

  a_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp.done |-> (st_q == ST_RE_T0 || st_q == ST_RE_T1 || st_q == ST_IM_T0 ||
                      st_q == ST_IM_T1 || st_q == ST_HX || st_q == ST_G ||
                      st_q == ST_PX || st_q == ST_PY || st_q == ST_CT))
    else $error("product finished with no step waiting for it");
`endif

endmodule

### test/tmk_kick_checker.sv
// scoreboard for the thin multipole kick: predicts each track transaction from
// the request stream and the apb writes it observes; needs tmk_pkg and tmk_channels
`timescale 1ns / 1ps

module tmk_kick_checker
  import tmk_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  tmk_req_if                req,
  tmk_rsp_if                rsp,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic              pready_i,
  input  logic [PaddrW-1:0] paddr_i,
  input  logic [DataW-1:0]  pwdata_i,
  output int unsigned       pending_o,
  output int unsigned       errors_o
);

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] mom_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] mom_y;
    logic signed [31:0] energy_dev;
    logic signed [31:0] path_len;
    logic               sat;
  } kicked_t;

  logic signed [CoefW-1:0] coef_mem [TableDepth];
  logic [31:0]             len_q;
  logic signed [31:0]      curv_q;
  logic [OrderW-1:0]       order_q;
  kicked_t                 kick_q [$];
  kicked_t                 oldest;
  int unsigned             mismatches;

  function automatic longint clamp_bits(input longint v, input int w, inout bit hit);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // floor(a*b / 2^F) taken exactly, then clamped to the coefficient width
  function automatic longint q_mul(input longint a, input longint b, inout bit hit);
    logic signed [127:0] wa;
    logic signed [127:0] wb;
    logic signed [127:0] prod;
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    wa   = a;
    wb   = b;
    hi   = (longint'(1) <<< (CoefW - 1)) - 1;
    lo   = -hi - 1;
    prod = (wa * wb) >>> FRAC_BITS;
    if (prod > hi) begin
      hit = 1'b1;
      return longint'(hi[63:0]);
    end
    if (prod < lo) begin
      hit = 1'b1;
      return longint'(lo[63:0]);
    end
    return longint'(prod[63:0]);
  endfunction

  function automatic kicked_t predict_kick(input logic signed [31:0] x, input logic signed [31:0] px,
                                           input logic signed [31:0] y, input logic signed [31:0] py,
                                           input logic signed [31:0] dl,
                                           input logic signed [31:0] ct);
    longint  re, im, nre, nim, hx, t, g, len, h, xl, yl, r_px, r_py, r_ct;
    int      n;
    int      i;
    bit      hit;
    kicked_t r;
    hit = 1'b0;
    len = longint'(len_q);
    h   = longint'(curv_q);
    xl  = longint'(x);
    yl  = longint'(y);
    n   = int'(order_q);
    if (n < 1) n = 1;
    if (n > ORDER_MAX) n = ORDER_MAX;
    re = longint'(coef_mem[n - 1]);
    im = longint'(coef_mem[ORDER_MAX + n - 1]);
    for (i = n - 2; i >= 0; i--) begin
      nre = clamp_bits(q_mul(re, xl, hit) - q_mul(im, yl, hit) + longint'(coef_mem[i]),
                       CoefW, hit);
      nim = clamp_bits(q_mul(im, xl, hit) + q_mul(re, yl, hit)
                       + longint'(coef_mem[ORDER_MAX + i]), CoefW, hit);
      re  = nre;
      im  = nim;
    end
    hx   = q_mul(xl, h, hit);
    t    = clamp_bits(longint'(dl) - hx, CoefW, hit);
    g    = clamp_bits(re - q_mul(t, h, hit), CoefW, hit);
    r_px = clamp_bits(longint'(px) - q_mul(g, len, hit), CoordW, hit);
    r_py = clamp_bits(longint'(py) + q_mul(im, len, hit), CoordW, hit);
    r_ct = clamp_bits(longint'(ct) + q_mul(hx, len, hit), CoordW, hit);
    r.pos_x      = x;
    r.mom_x      = r_px[31:0];
    r.pos_y      = y;
    r.mom_y      = r_py[31:0];
    r.energy_dev = dl;
    r.path_len   = r_ct[31:0];
    r.sat        = hit;
    return r;
  endfunction

  task automatic check_word(input string tag, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t %s expected %h actual %h", $time, tag, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (coef_mem[k]) coef_mem[k] = '0;
      len_q   = '0;
      curv_q  = '0;
      order_q = OrderW'(1);
      kick_q.delete();
      mismatches = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[PaddrW-1:2]))
          REG_KICK_LENGTH: len_q = pwdata_i;
          REG_INV_RADIUS:  curv_q = pwdata_i;
          REG_FIELD_ORDER: order_q = pwdata_i[OrderW-1:0];
          default: ;
        endcase
      end
      // results come from earlier transactions, so retire before taking new ones
      if (rsp.valid && rsp.ready) begin
        if (kick_q.size() == 0) begin
          $display("%0t result transaction expected none actual new_mom_x %h",
                   $time, rsp.new_mom_x);
          mismatches++;
        end else begin
          oldest = kick_q.pop_front();
          check_word("new_pos_x", oldest.pos_x, rsp.new_pos_x);
          check_word("new_mom_x", oldest.mom_x, rsp.new_mom_x);
          check_word("new_pos_y", oldest.pos_y, rsp.new_pos_y);
          check_word("new_mom_y", oldest.mom_y, rsp.new_mom_y);
          check_word("new_energy_dev", oldest.energy_dev, rsp.new_energy_dev);
          check_word("new_path_len", oldest.path_len, rsp.new_path_len);
          check_word("sat_flag", 32'(oldest.sat), 32'(rsp.sat_flag));
        end
      end
      if (req.valid && req.ready) begin
        if (req.req_type == REQ_WRITE) begin
          if (int'(req.coef_index) < ORDER_MAX) begin
            coef_mem[int'(req.coef_skew) * ORDER_MAX + int'(req.coef_index)] = req.coef_value;
          end
        end else begin
          kick_q.push_back(predict_kick(req.pos_x, req.mom_x, req.pos_y, req.mom_y,
                                        req.energy_dev, req.path_len));
        end
      end
    end
    pending_o <= kick_q.size();
    errors_o  <= mismatches;
  end

endmodule

### test/thin_multipole_kick_tb.sv
// testbench top for thin_multipole_kick: drives requests, apb writes and result
// back-pressure; needs tmk_pkg, tmk_channels, the block and tmk_kick_checker
`timescale 1ns / 1ps

module thin_multipole_kick_tb;
  import tmk_pkg::*;

  localparam int unsigned CycleLimit   = 1_000_000;
  localparam int          SettleCycles = 80;
  localparam int          NumPhases    = 8;
  localparam int          PhaseItems   = 137;

  typedef struct {
    logic               kind;
    logic [1:0]         slot;
    logic               skew;
    logic signed [47:0] coef;
    logic signed [31:0] x, px, y, py, dl, ct;
  } kick_req_t;

  logic              clk;
  logic              rst_n;
  logic              psel, penable, pwrite;
  logic [PaddrW-1:0] paddr;
  logic [DataW-1:0]  pwdata;
  logic [DataW-1:0]  prdata;
  logic              pready;
  logic              sink_ready = 1'b0;
  int unsigned       stall_left = 0;
  int unsigned       stall_draw;
  int unsigned       gap_pct    = 0;
  int unsigned       stall_pct  = 0;
  int unsigned       cycle_count = 0;
  int unsigned       pending;
  int unsigned       errors;
  logic [31:0]       len_cfg, curv_cfg;
  logic [2:0]        ord_cfg;

  tmk_req_if req_ch ();
  tmk_rsp_if rsp_ch ();

  assign rsp_ch.ready = sink_ready;

  thin_multipole_kick uut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tmk_kick_checker checker_i (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .pready_i  (pready),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .pending_o (pending),
    .errors_o  (errors)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap(input int unsigned pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
    return $urandom_range(1, 3);
  endfunction

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      sink_ready <= 1'b0;
    end else begin
      stall_draw = pick_gap(stall_pct);
      sink_ready <= (stall_draw == 0);
      stall_left <= (stall_draw == 0) ? 0 : stall_draw - 1;
    end
  end

  function automatic logic signed [31:0] pick_coord();
    int v;
    case ($urandom_range(0, 9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return -32'sd1;
      4, 5, 6, 7: begin
        v = int'($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
        return v;
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [47:0] pick_coef();
    int     v;
    longint w;
    case ($urandom_range(0, 9))
      0: return {1'b0, {47{1'b1}}};
      1: return {1'b1, {47{1'b0}}};
      2: return '0;
      3, 4, 5, 6: begin
        v = int'($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
        return v;
      end
      7: begin
        w = longint'($signed($urandom)) <<< $urandom_range(0, 15);
        return w[47:0];
      end
      default: return 48'({$urandom, $urandom});
    endcase
  endfunction

  function automatic kick_req_t make_track(input logic signed [31:0] x, input logic signed [31:0] px,
                                           input logic signed [31:0] y, input logic signed [31:0] py,
                                           input logic signed [31:0] dl,
                                           input logic signed [31:0] ct);
    kick_req_t r;
    r.kind = REQ_TRACK;
    r.slot = 2'($urandom);
    r.skew = 1'($urandom);
    r.coef = 48'({$urandom, $urandom});
    r.x  = x;
    r.px = px;
    r.y  = y;
    r.py = py;
    r.dl = dl;
    r.ct = ct;
    return r;
  endfunction

  function automatic kick_req_t make_write(input logic [1:0] slot, input logic skew,
                                           input logic signed [47:0] coef);
    kick_req_t r;
    r.kind = REQ_WRITE;
    r.slot = slot;
    r.skew = skew;
    r.coef = coef;
    r.x  = $urandom;
    r.px = $urandom;
    r.y  = $urandom;
    r.py = $urandom;
    r.dl = $urandom;
    r.ct = $urandom;
    return r;
  endfunction

  function automatic kick_req_t random_req();
    if ($urandom_range(0, 99) < 15) begin
      return make_write(2'($urandom), 1'($urandom), pick_coef());
    end
    return make_track(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                      pick_coord(), pick_coord());
  endfunction

  task automatic send_item(input kick_req_t r);
    int unsigned gap;
    gap = pick_gap(gap_pct);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= r.kind;
    req_ch.coef_index <= r.slot;
    req_ch.coef_skew  <= r.skew;
    req_ch.coef_value <= r.coef;
    req_ch.pos_x      <= r.x;
    req_ch.mom_x      <= r.px;
    req_ch.pos_y      <= r.y;
    req_ch.mom_y      <= r.py;
    req_ch.energy_dev <= r.dl;
    req_ch.path_len   <= r.ct;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic reg_write(input reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PaddrW'(4 * int'(idx));
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // let every predicted result arrive, then give the block time to go idle
  task automatic quiesce();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic apply_config(input logic [31:0] len, input logic [31:0] curv,
                              input logic [2:0] ord);
    reg_write(REG_KICK_LENGTH, len);
    reg_write(REG_INV_RADIUS, curv);
    reg_write(REG_FIELD_ORDER, 32'(ord));
  endtask

  initial begin
    rst_n   = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    req_ch.valid      = 1'b0;
    req_ch.req_type   = REQ_TRACK;
    req_ch.coef_index = '0;
    req_ch.coef_skew  = 1'b0;
    req_ch.coef_value = '0;
    req_ch.pos_x      = '0;
    req_ch.mom_x      = '0;
    req_ch.pos_y      = '0;
    req_ch.mom_y      = '0;
    req_ch.energy_dev = '0;
    req_ch.path_len   = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset configuration: zero length, so coordinates pass straight through
    send_item(make_track(32'sh0100_0000, 32'sh0080_0000, -32'sh0100_0000, 32'sh0000_1000,
                         32'sh0001_0000, 32'sh7FFF_FFF0));
    quiesce();
    apply_config(32'h0100_0000, 32'h0040_0000, 3'd4);

    send_item(make_write(2'd0, 1'b0, 48'sh0000_0100_0000));
    send_item(make_write(2'd1, 1'b0, 48'sh0000_0200_0000));
    send_item(make_write(2'd2, 1'b0, {1'b0, {47{1'b1}}}));
    send_item(make_write(2'd3, 1'b0, -48'sh0000_0080_0000));
    send_item(make_write(2'd0, 1'b1, -48'sh0000_0100_0000));
    send_item(make_write(2'd1, 1'b1, {1'b1, {47{1'b0}}}));
    send_item(make_write(2'd2, 1'b1, 48'sh0000_0040_0000));
    send_item(make_write(2'd3, 1'b1, 48'sh0000_0300_0000));
    send_item(make_track('0, 32'sh0010_0000, '0, -32'sh0010_0000, 32'sh0002_0000, '0));
    send_item(make_track(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                         32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    send_item(make_track(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                         32'sh8000_0000, 32'sh8000_0000));
    send_item(make_track(32'sh0100_0000, '0, -32'sh0100_0000, '0, '0, '0));
    // tame the extreme terms so the next particles stay off the rails
    send_item(make_write(2'd2, 1'b0, 48'sh0000_0019_999A));
    send_item(make_write(2'd1, 1'b1, -48'sh0000_0033_3333));
    send_item(make_track(32'sh0020_0000, -32'sh0001_0000, -32'sh0030_0000, 32'sh0004_0000,
                         32'sh0000_8000, 32'sh0100_0000));
    send_item(make_track(32'sh7FFF_FFFF, '0, 32'sh8000_0000, '0, 32'sh7FFF_FFFF, '0));
    send_item(make_track(-32'sd1, 32'sd1, 32'sd1, -32'sd1, -32'sd1, 32'sd1));

    for (int phase = 0; phase < NumPhases; phase++) begin
      quiesce();
      case (phase)
        0: begin len_cfg = 32'h0100_0000; curv_cfg = '0; ord_cfg = 3'd4; end
        1: begin len_cfg = 32'hFFFF_FFFF; curv_cfg = 32'h7FFF_FFFF; ord_cfg = 3'd7; end
        2: begin len_cfg = '0; curv_cfg = 32'h8000_0000; ord_cfg = 3'd0; end
        3: begin
          len_cfg  = $urandom_range(0, 32'h0200_0000);
          curv_cfg = int'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
          ord_cfg  = 3'd2;
        end
        4: begin len_cfg = $urandom_range(0, 32'h0200_0000); curv_cfg = '0; ord_cfg = 3'd3; end
        5: begin len_cfg = $urandom; curv_cfg = $urandom; ord_cfg = 3'($urandom); end
        6: begin
          len_cfg  = $urandom_range(0, 32'h0200_0000);
          curv_cfg = int'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
          ord_cfg  = 3'd4;
        end
        default: begin len_cfg = 32'h0080_0000; curv_cfg = 32'hFF00_0000; ord_cfg = 3'd1; end
      endcase
      apply_config(len_cfg, curv_cfg, ord_cfg);
      // phases 0 and 4 run with no gaps on either side
      gap_pct   = (phase == 0 || phase == 4) ? 0 : $urandom_range(10, 40);
      stall_pct = (phase == 0 || phase == 4) ? 0 : $urandom_range(10, 40);
      for (int k = 0; k < PhaseItems; k++) begin
        if (phase == 3 && k == PhaseItems / 2) quiesce();
        send_item(random_req());
      end
    end

    quiesce();
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
